FILE: rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
package ile_pkg;

	localparam int CAPACITY = 64;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		FUNC_READ   = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_APPEND = 2'd2,
		FUNC_DELETE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]              func;
		logic [POS_W-1:0]        position;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [1:0]              status;
		logic [CNT_W-1:0]        entry_count;
	} rsp_t;

	typedef struct packed {
		logic                     en;
		op_t                      op;
		logic [IDX_W-1:0]         pos;
		logic signed [WORD_W-1:0] value;
	} cell_ctl_t;

endpackage

FILE: rtl/ile_ctrl.sv
// Request decode: range and full checks, shift control and next entry count.
module ile_ctrl import ile_pkg::*; (
	input  logic                     fire,
	input  req_t                     req,
	input  logic [CNT_W-1:0]         count,
	output cell_ctl_t                ctl,
	output status_t                  status,
	output logic                     read_hit,
	output logic [CNT_W-1:0]         next_count
);

	logic [POS_W:0] pos_x;
	logic [POS_W:0] cnt_x;
	logic           full;

	assign pos_x = {1'b0, req.position};
	assign cnt_x = (POS_W + 1)'(count);
	assign full  = (count == FULL_COUNT);

	always_comb begin
		ctl.en     = fire;
		ctl.op     = OP_HOLD;
		ctl.pos    = req.position[IDX_W-1:0];
		ctl.value  = req.value;
		status     = ST_OK;
		read_hit   = 1'b0;
		next_count = count;
		case (func_t'(req.func))
			FUNC_READ: begin
				if (pos_x < cnt_x) begin
					read_hit = 1'b1;
				end else begin
					status = ST_RANGE;
				end
			end
			FUNC_INSERT: begin
				if (pos_x > cnt_x) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctl.op     = OP_INSERT;
					next_count = count + CNT_W'(1);
				end
			end
			FUNC_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl.op     = OP_INSERT;
					ctl.pos    = count[IDX_W-1:0];
					next_count = count + CNT_W'(1);
				end
			end
			FUNC_DELETE: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					ctl.op     = OP_DELETE;
					next_count = count - CNT_W'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

endmodule

FILE: rtl/ile_cell.sv
// One list position: holds a word and shifts it to or from its neighbors.
module ile_cell import ile_pkg::*; (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic [IDX_W-1:0]         cell_index,
	input  logic signed [WORD_W-1:0] left_word,
	input  logic signed [WORD_W-1:0] right_word,
	output logic signed [WORD_W-1:0] word
);

	logic signed [WORD_W-1:0] word_q;
	logic signed [WORD_W-1:0] word_d;

	always_comb begin
		word_d = word_q;
		case (ctl.op)
			OP_INSERT: begin
				if (cell_index > ctl.pos) begin
					word_d = left_word;
				end else if (cell_index == ctl.pos) begin
					word_d = ctl.value;
				end
			end
			OP_DELETE: begin
				if (cell_index >= ctl.pos) begin
					word_d = right_word;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			word_q <= word_d;
		end
	end

	assign word = word_q;

endmodule

FILE: rtl/indexed_list_engine.sv
// Top level of the indexed list engine: request stage, cell row and response register.
//
// An ordered list of up to 64 signed 32-bit words held in a row of cells.
// Requests enter on req_valid/req_ready with a req struct (func, position,
// value); each request returns exactly one response on rsp_valid/rsp_ready
// with the word read, a status and the entry count after the request.
// A request is captured in a request register; once the response register
// is empty or being taken, the cells compare their own position with the
// request position and shift, load or hold in parallel while the response
// register is loaded. One request is taken per cycle while responses are
// taken; a new request may enter while a finished response is still waiting.
// If the receiver stalls, the response register holds, the request register
// fills, and req_ready drops until the response is taken.
// Reset clears the entry count and all valid flags; the list is then empty.
// Cell contents are not reset; positions at or past the count are never read.
module indexed_list_engine import ile_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	req_t                     req_s1;
	logic                     valid_s1;
	logic [CNT_W-1:0]         count_q;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;
	logic                     advance;
	logic                     fire;
	cell_ctl_t                ctl;
	status_t                  status;
	logic                     read_hit;
	logic [CNT_W-1:0]         next_count;
	logic signed [WORD_W-1:0] cell_word [CAPACITY];
	logic signed [WORD_W-1:0] rd_word;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign fire      = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	ile_ctrl u_ctrl (
		.fire       (fire),
		.req        (req_s1),
		.count      (count_q),
		.ctl        (ctl),
		.status     (status),
		.read_hit   (read_hit),
		.next_count (next_count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_body
			assign right_w = cell_word[i+1];
		end
		ile_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cell_index (IDX_W'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i])
		);
	end

	always_comb begin
		if (read_hit) begin
			rd_word = cell_word[req_s1.position[IDX_W-1:0]];
		end else if (func_t'(req_s1.func) == FUNC_READ) begin
			rd_word = '1;
		end else begin
			rd_word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= next_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.read_value  <= rd_word;
			rsp_q.status      <= status;
			rsp_q.entry_count <= next_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: bench/ile_list_checker.sv
// Checker for the indexed list engine: tracks the list contents and compares every response.
`timescale 1ns / 100ps

module ile_list_checker import ile_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   rsp_total,
	output int   full_total,
	output int   range_total,
	output int   peak_length
);

	logic signed [WORD_W-1:0] list_words [CAPACITY];
	int unsigned list_len = 0;
	rsp_t awaited_rsps [$];
	int errs = 0;
	int seen = 0;
	int fulls = 0;
	int ranges = 0;
	int peak = 0;

	function automatic rsp_t list_update(req_t r);
		rsp_t res;
		int unsigned p;
		res = '0;
		p = r.position;
		case (r.func)
			FUNC_READ: begin
				if (p < list_len) begin
					res.read_value = list_words[p];
				end else begin
					res.read_value = -1;
					res.status = ST_RANGE;
				end
			end
			FUNC_INSERT, FUNC_APPEND: begin
				if (r.func == FUNC_APPEND)
					p = list_len;
				if (p > list_len) begin
					res.status = ST_RANGE;
				end else if (list_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int k = list_len; k > p; k--)
						list_words[k] = list_words[k-1];
					list_words[p] = r.value;
					list_len++;
				end
			end
			default: begin
				if (p >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (int k = p; k + 1 < list_len; k++)
						list_words[k] = list_words[k+1];
					list_len--;
				end
			end
		endcase
		res.entry_count = CNT_W'(list_len);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			list_len = 0;
			awaited_rsps.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				seen++;
				if (awaited_rsps.size() == 0) begin
					errs++;
					$display("%0t: response with no request outstanding, expected none, got %p",
						$time, rsp);
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.read_value !== want.read_value) begin
						errs++;
						$display("%0t: read_value expected %0d got %0d", $time,
							$signed(want.read_value), $signed(rsp.read_value));
					end
					if (rsp.status !== want.status) begin
						errs++;
						$display("%0t: status expected %0d got %0d", $time,
							want.status, rsp.status);
					end
					if (rsp.entry_count !== want.entry_count) begin
						errs++;
						$display("%0t: entry_count expected %0d got %0d", $time,
							want.entry_count, rsp.entry_count);
					end
				end
			end
			if (req_valid && req_ready) begin
				want = list_update(req);
				if (want.status == ST_FULL)
					fulls++;
				if (want.status == ST_RANGE)
					ranges++;
				if (list_len > peak)
					peak = list_len;
				awaited_rsps.push_back(want);
			end
		end
		fail_count <= errs;
		pending <= awaited_rsps.size();
		rsp_total <= seen;
		full_total <= fulls;
		range_total <= ranges;
		peak_length <= peak;
	end

endmodule

FILE: bench/tb_indexed_list_engine.sv
// Top of the indexed list engine testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_indexed_list_engine;
	import ile_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic calm = 1'b0;
	int unsigned shadow_len = 0;
	int cycles = 0;

	int fail_count;
	int pending;
	int rsp_total;
	int full_total;
	int range_total;
	int peak_length;

	indexed_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	ile_list_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.pending     (pending),
		.rsp_total   (rsp_total),
		.full_total  (full_total),
		.range_total (range_total),
		.peak_length (peak_length)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= 34);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic req_t mk(func_t f, int unsigned p, logic signed [WORD_W-1:0] v);
		req_t r;
		r.func = f;
		r.position = POS_W'(p);
		r.value = v;
		return r;
	endfunction

	// Only the entry count is tracked here, to steer positions into range.
	function automatic void track_length(req_t r);
		case (r.func)
			FUNC_INSERT:
				if (r.position <= shadow_len && shadow_len < CAPACITY)
					shadow_len++;
			FUNC_APPEND:
				if (shadow_len < CAPACITY)
					shadow_len++;
			FUNC_DELETE:
				if (r.position < shadow_len)
					shadow_len--;
			default: ;
		endcase
	endfunction

	function automatic req_t pick_request(bit grow);
		req_t r;
		int unsigned roll;
		int unsigned cut_app, cut_ins, cut_rd, cut_del;
		logic signed [WORD_W-1:0] v;
		roll = $urandom_range(0, 99);
		case ($urandom_range(0, 11))
			0: v = 32'sh7FFF_FFFF;
			1: v = 32'sh8000_0000;
			2: v = '0;
			3: v = -1;
			default: v = $urandom;
		endcase
		if (grow) begin
			cut_app = 35; cut_ins = 60; cut_rd = 80; cut_del = 92;
		end else begin
			cut_app = 10; cut_ins = 20; cut_rd = 45; cut_del = 90;
		end
		if (roll < cut_app)
			r = mk(FUNC_APPEND, $urandom_range(0, 127), v);
		else if (roll < cut_ins)
			r = mk(FUNC_INSERT, $urandom_range(0, shadow_len), v);
		else if (roll < cut_rd)
			r = mk(FUNC_READ, shadow_len ? $urandom_range(0, shadow_len - 1) : 0, v);
		else if (roll < cut_del)
			r = mk(FUNC_DELETE, shadow_len ? $urandom_range(0, shadow_len - 1) : 0, v);
		else
			r = mk(func_t'($urandom_range(0, 3)), $urandom_range(0, 127), v);
		return r;
	endfunction

	task automatic issue(input req_t item);
		while (!calm && $urandom_range(0, 99) < 34) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		track_length(item);
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list first: read, delete and insert past the end are out of range; then a short list is built and edited.
		issue(mk(FUNC_READ, 0, 32'sd11));
		issue(mk(FUNC_DELETE, 0, 32'sd0));
		issue(mk(FUNC_INSERT, 1, 32'sd7));
		issue(mk(FUNC_INSERT, 0, 32'sh7FFF_FFFF));
		issue(mk(FUNC_APPEND, 0, 32'sh8000_0000));
		issue(mk(FUNC_INSERT, 2, 32'sd0));
		issue(mk(FUNC_INSERT, 1, -1));
		issue(mk(FUNC_INSERT, 0, 32'sh5555_AAAA));
		for (int k = 0; k < 6; k++)
			issue(mk(FUNC_READ, k, 32'sd0));
		issue(mk(FUNC_READ, 127, 32'sd0));
		issue(mk(FUNC_DELETE, 127, 32'sd0));
		issue(mk(FUNC_INSERT, 127, 32'sd5));
		issue(mk(FUNC_APPEND, 127, 32'shAAAA_5555));
		issue(mk(FUNC_DELETE, 0, 32'sd0));
		issue(mk(FUNC_DELETE, 4, 32'sd0));
		issue(mk(FUNC_DELETE, 1, 32'sd0));
		issue(mk(FUNC_READ, 0, 32'sd0));
		issue(mk(FUNC_READ, 2, 32'sd0));

		// Alternate filling and draining so the full and empty ends are both reached.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 400)
				calm <= 1'b1;
			if (i == 550)
				calm <= 1'b0;
			issue(pick_request((i / 120) % 2 == 0));
		end
		req_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d responses; the list peaked at %0d entries.",
			rsp_total, peak_length);
		$display("Saw %0d full-list rejections and %0d out-of-range requests.",
			full_total, range_total);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
